// File: rtl/core/cci_pkg.sv
// shared types, command codes and tables of the coin and credit i/o controller
`timescale 1ns / 1ps
`default_nettype none

package cci_pkg;

    localparam int PARAM_COUNT = 16;
    localparam int PARAM_IDX_W = $clog2(PARAM_COUNT);
    localparam int RATE_COUNT  = 6;
    localparam int COIN_COUNT  = 3;
    localparam int SOUND_LEN   = 7;

    // bus operations
    localparam logic [1:0] OP_CMD_WR  = 2'd0;
    localparam logic [1:0] OP_CMD_RD  = 2'd1;
    localparam logic [1:0] OP_DATA_WR = 2'd2;
    localparam logic [1:0] OP_DATA_RD = 2'd3;

    // commands
    localparam logic [7:0] CMD_SETUP   = 8'hA1;
    localparam logic [7:0] CMD_SOUND   = 8'h68;
    localparam logic [7:0] CMD_READ_A  = 8'h71;
    localparam logic [7:0] CMD_READ_B  = 8'hB1;
    localparam logic [7:0] CMD_PROTECT = 8'h74;
    localparam logic [7:0] CMD_NMI_OFF = 8'h10;

    // data values
    localparam logic [7:0] SETUP_SWITCH = 8'h05;
    localparam logic [7:0] PROT_OK      = 8'h05;
    localparam logic [7:0] PROT_FAIL    = 8'h95;
    localparam logic [7:0] PROT_KEY_A   = 8'h80;
    localparam logic [7:0] PROT_KEY_B   = 8'h10;

    // offsets within the data window
    localparam logic [3:0] OFF_MODE  = 4'd0;
    localparam logic [3:0] OFF_RATES = 4'd7;
    localparam logic [3:0] OFF_SOUND = 4'd6;
    localparam logic [3:0] OFF_COIN  = 4'd0;
    localparam logic [3:0] OFF_JOY1  = 4'd1;
    localparam logic [3:0] OFF_JOY2  = 4'd2;
    localparam logic [3:0] OFF_PROT  = 4'd3;

    localparam logic [8:0] CREDIT_MAX   = 9'd99;
    localparam logic [8:0] CREDIT_LIMIT = 9'd353;
    localparam logic [8:0] FREE_CREDITS = 9'd2;

    // sound trigger codes
    localparam logic [1:0] SND_NONE = 2'd0;
    localparam logic [1:0] SND_A    = 2'd1;
    localparam logic [1:0] SND_B    = 2'd2;

    localparam logic [7:0] SOUND_PAT_A [SOUND_LEN] =
        '{8'h40, 8'h40, 8'h40, 8'h01, 8'hFF, 8'h00, 8'h20};
    localparam logic [7:0] SOUND_PAT_B [SOUND_LEN] =
        '{8'h30, 8'h40, 8'h00, 8'h02, 8'hDF, 8'h00, 8'h10};

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] offset;
        logic [7:0] data;
        logic [7:0] port_value;
    } cci_item_t;

    typedef struct packed {
        logic [9:0] read_data;
        logic       read_valid;
        logic [1:0] sound_trigger;
        logic       nmi_running;
    } cci_result_t;

    // joystick nibble to direction, 0..7 clockwise from up, 8 centered
    function automatic logic [3:0] dir_map(input logic [3:0] joy);
        logic [3:0] d;
        unique case (joy)
            4'h0, 4'h1, 4'h2, 4'h3: d = 4'd5;
            4'h4, 4'h6:             d = 4'd7;
            4'h5, 4'h7:             d = 4'd6;
            4'h8, 4'h9:             d = 4'd3;
            4'hA, 4'hB:             d = 4'd4;
            4'hC:                   d = 4'd1;
            4'hD:                   d = 4'd2;
            4'hE:                   d = 4'd0;
            default:                d = 4'd8;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cci_in_stage.sv
// input register holding one bus access beat ahead of the core
`timescale 1ns / 1ps
`default_nettype none

module cci_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cci_pkg::cci_item_t s_item,
    input  wire logic               advance,
    output logic                    item_valid,
    output cci_pkg::cci_item_t      item
);

    logic               valid_reg;
    logic               valid_next;
    cci_pkg::cci_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/cci_core.sv
// controller state and the single-pass logic that answers one bus access
`timescale 1ns / 1ps
`default_nettype none

module cci_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire cci_pkg::cci_item_t item,
    output cci_pkg::cci_result_t    result
);

    typedef struct packed {
        logic [8:0] credit;
        logic [7:0] pend;
    } coin_t;

    logic [7:0] command_reg;
    logic [7:0] command_next;
    logic       switch_mode_reg;
    logic       switch_mode_next;
    logic [8:0] credit_count_reg;
    logic [8:0] credit_count_next;
    logic       nmi_on_reg;
    logic       nmi_on_next;
    logic [7:0] param_bytes_reg [cci_pkg::PARAM_COUNT];
    logic [7:0] coin_rates_reg  [cci_pkg::RATE_COUNT];
    logic [7:0] coin_rates_next [cci_pkg::RATE_COUNT];
    logic [7:0] coins_pending_reg  [cci_pkg::COIN_COUNT];
    logic [7:0] coins_pending_next [cci_pkg::COIN_COUNT];

    logic [7:0] post_bytes [cci_pkg::SOUND_LEN];
    logic       param_wr;
    logic       match_a;
    logic       match_b;
    logic       read_cmd;
    coin_t      step_left;
    coin_t      step_right;
    coin_t      step_aux;
    logic [8:0] credit_mid;
    logic [8:0] credit_fin;
    logic [16:0] bcd_prod;
    logic [5:0]  bcd_tens;
    logic [8:0]  bcd_diff;
    logic [9:0]  credit_bcd;

    function automatic coin_t coin_step(input logic hit, input logic [8:0] credit,
                                        input logic [7:0] pend, input logic [7:0] cpc,
                                        input logic [7:0] add);
        coin_t      r;
        logic [7:0] inc;
        r.credit = credit;
        r.pend   = pend;
        inc      = pend + 8'd1;
        if (hit && credit < cci_pkg::CREDIT_MAX) begin
            if (inc >= cpc) begin
                r.credit = credit + {1'b0, add};
                r.pend   = '0;
            end else begin
                r.pend = inc;
            end
        end
        return r;
    endfunction

    assign param_wr = (item.op == cci_pkg::OP_DATA_WR)
                   && ({28'd0, item.offset} < cci_pkg::PARAM_COUNT);

    // first seven parameter bytes as they stand after this access
    always_comb begin
        for (int i = 0; i < cci_pkg::SOUND_LEN; i++) begin
            post_bytes[i] = (param_wr && item.offset == 4'(i))
                          ? item.data : param_bytes_reg[i];
        end
    end

    always_comb begin
        match_a = 1'b1;
        match_b = 1'b1;
        for (int i = 0; i < cci_pkg::SOUND_LEN; i++) begin
            if (post_bytes[i] != cci_pkg::SOUND_PAT_A[i]) match_a = 1'b0;
            if (post_bytes[i] != cci_pkg::SOUND_PAT_B[i]) match_b = 1'b0;
        end
    end

    // coin counting in the order left, right, aux
    always_comb begin
        step_left  = coin_step(!item.port_value[4], credit_count_reg, coins_pending_reg[0],
                               coin_rates_reg[2], coin_rates_reg[3]);
        step_right = coin_step(!item.port_value[5], step_left.credit, coins_pending_reg[1],
                               coin_rates_reg[4], coin_rates_reg[5]);
        step_aux   = coin_step(!item.port_value[6], step_right.credit, coins_pending_reg[2],
                               coin_rates_reg[0], coin_rates_reg[1]);
        credit_mid = (coin_rates_reg[2] != 8'd0) ? step_aux.credit : cci_pkg::FREE_CREDITS;
        credit_fin = credit_mid;
        if (!item.port_value[2] && credit_fin >= 9'd1) credit_fin = credit_fin - 9'd1;
        if (!item.port_value[3] && credit_fin >= 9'd2) credit_fin = credit_fin - 9'd2;
    end

    // divide by ten through the reciprocal 205 / 2048
    assign bcd_prod   = {8'd0, credit_fin} * 17'd205;
    assign bcd_tens   = bcd_prod[16:11];
    assign bcd_diff   = credit_fin - ({3'd0, bcd_tens} * 9'd10);
    assign credit_bcd = {bcd_tens, 4'd0} + {6'd0, bcd_diff[3:0]};

    assign read_cmd = (command_reg == cci_pkg::CMD_READ_A)
                   || (command_reg == cci_pkg::CMD_READ_B);

    always_comb begin
        command_next      = command_reg;
        switch_mode_next  = switch_mode_reg;
        credit_count_next = credit_count_reg;
        nmi_on_next       = nmi_on_reg;
        coin_rates_next   = coin_rates_reg;
        coins_pending_next = coins_pending_reg;
        result            = '0;

        unique case (item.op)
            cci_pkg::OP_CMD_WR: begin
                command_next = item.data;
                nmi_on_next  = (item.data != cci_pkg::CMD_NMI_OFF);
            end
            cci_pkg::OP_CMD_RD: begin
                result.read_data  = {2'd0, command_reg};
                result.read_valid = 1'b1;
            end
            cci_pkg::OP_DATA_WR: begin
                if (command_reg == cci_pkg::CMD_SETUP) begin
                    if (item.offset == cci_pkg::OFF_MODE) begin
                        if (item.data == cci_pkg::SETUP_SWITCH) begin
                            switch_mode_next = 1'b1;
                        end else begin
                            switch_mode_next  = 1'b0;
                            credit_count_next = '0;
                        end
                    end else if (item.offset == cci_pkg::OFF_RATES) begin
                        for (int i = 0; i < cci_pkg::RATE_COUNT; i++) begin
                            coin_rates_next[i] = post_bytes[i + 1];
                        end
                    end
                end else if (command_reg == cci_pkg::CMD_SOUND
                             && item.offset == cci_pkg::OFF_SOUND) begin
                    if (match_a) begin
                        result.sound_trigger = cci_pkg::SND_A;
                    end else if (match_b) begin
                        result.sound_trigger = cci_pkg::SND_B;
                    end
                end
            end
            default: begin
                if (read_cmd) begin
                    if (item.offset == cci_pkg::OFF_COIN) begin
                        result.read_valid = 1'b1;
                        if (switch_mode_reg) begin
                            result.read_data = {2'd0, item.port_value};
                        end else begin
                            result.read_data  = credit_bcd;
                            credit_count_next = credit_fin;
                            if (coin_rates_reg[2] != 8'd0) begin
                                coins_pending_next[0] = step_left.pend;
                                coins_pending_next[1] = step_right.pend;
                                coins_pending_next[2] = step_aux.pend;
                            end
                        end
                    end else if (item.offset == cci_pkg::OFF_JOY1
                                 || item.offset == cci_pkg::OFF_JOY2) begin
                        result.read_valid = 1'b1;
                        if (switch_mode_reg) begin
                            result.read_data = {2'd0, item.port_value};
                        end else begin
                            result.read_data = {2'd0, item.port_value[7:4],
                                                cci_pkg::dir_map(item.port_value[3:0])};
                        end
                    end
                end else if (command_reg == cci_pkg::CMD_PROTECT) begin
                    result.read_valid = 1'b1;
                    if (item.offset == cci_pkg::OFF_PROT) begin
                        result.read_data = (param_bytes_reg[0] == cci_pkg::PROT_KEY_A
                                            || param_bytes_reg[0] == cci_pkg::PROT_KEY_B)
                                         ? {2'd0, cci_pkg::PROT_OK}
                                         : {2'd0, cci_pkg::PROT_FAIL};
                    end
                end
            end
        endcase

        result.nmi_running = nmi_on_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg      <= '0;
            switch_mode_reg  <= 1'b0;
            credit_count_reg <= '0;
            nmi_on_reg       <= 1'b0;
            for (int i = 0; i < cci_pkg::PARAM_COUNT; i++) param_bytes_reg[i] <= '0;
            for (int i = 0; i < cci_pkg::RATE_COUNT; i++) coin_rates_reg[i] <= '0;
            for (int i = 0; i < cci_pkg::COIN_COUNT; i++) coins_pending_reg[i] <= '0;
        end else if (fire) begin
            command_reg       <= command_next;
            switch_mode_reg   <= switch_mode_next;
            credit_count_reg  <= credit_count_next;
            nmi_on_reg        <= nmi_on_next;
            coin_rates_reg    <= coin_rates_next;
            coins_pending_reg <= coins_pending_next;
            if (param_wr) begin
                param_bytes_reg[item.offset[cci_pkg::PARAM_IDX_W-1:0]] <= item.data;
            end
        end
    end

    a_credit_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_count_reg <= cci_pkg::CREDIT_LIMIT)
        else $error("credit count beyond its ceiling");

    a_nmi_off: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == cci_pkg::OP_CMD_WR && item.data == cci_pkg::CMD_NMI_OFF
        |=> !nmi_on_reg)
        else $error("interrupt still enabled after stop command");

    a_sound_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        result.sound_trigger != cci_pkg::SND_NONE
        |-> item.op == cci_pkg::OP_DATA_WR && command_reg == cci_pkg::CMD_SOUND)
        else $error("sound trigger outside a sound pattern write");

    a_answer_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        result.read_valid |-> item.op == cci_pkg::OP_CMD_RD || item.op == cci_pkg::OP_DATA_RD)
        else $error("answer flagged for a write");

endmodule

`default_nettype wire

// File: rtl/core/cci_out_stage.sv
// result register that holds a finished beat until the receiver takes it
`timescale 1ns / 1ps
`default_nettype none

module cci_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire cci_pkg::cci_result_t result,
    output logic                      load_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output cci_pkg::cci_result_t      m_result
);

    logic                 valid_reg;
    logic                 valid_next;
    cci_pkg::cci_result_t result_reg;

    assign load_ready = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/coin_credit_io_controller_unit.sv
// top level of the coin and credit i/o controller
//
// one bus access enters per beat on the s_ channel (op, offset, data, port_value)
// and exactly one result beat leaves on the m_ channel (read_data, read_valid,
// sound_trigger, nmi_running). command writes, data writes and reads all give a
// result beat; writes answer with read_valid low.
// from acceptance the access sits in the input register, then the single-pass logic
// updates the controller state and loads the result register, which raises m_valid.
// throughput is one beat per cycle while m_ready stays high; back-to-back accesses
// see the state left by the previous one.
// when the receiver holds m_ready low the result register keeps its beat, the
// input register keeps the next access, and s_ready drops once both are full.
// synchronous reset (aresetn low) clears the command, credit count, coin rates,
// pending coins, parameter bytes, mode and interrupt enable, and empties both
// registers.
`timescale 1ns / 1ps
`default_nettype none

module coin_credit_io_controller_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [3:0] s_offset,
    input  wire logic [7:0] s_data,
    input  wire logic [7:0] s_port_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [9:0]      m_read_data,
    output logic            m_read_valid,
    output logic [1:0]      m_sound_trigger,
    output logic            m_nmi_running
);

    cci_pkg::cci_item_t   s_item;
    cci_pkg::cci_item_t   item;
    cci_pkg::cci_result_t result;
    cci_pkg::cci_result_t m_result;
    logic                 item_valid;
    logic                 load_ready;
    logic                 advance;

    assign s_item.op         = s_op;
    assign s_item.offset     = s_offset;
    assign s_item.data       = s_data;
    assign s_item.port_value = s_port_value;

    assign advance = item_valid && load_ready;

    cci_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cci_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item),
        .result  (result)
    );

    cci_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result     (result),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_read_data     = m_result.read_data;
    assign m_read_valid    = m_result.read_valid;
    assign m_sound_trigger = m_result.sound_trigger;
    assign m_nmi_running   = m_result.nmi_running;

endmodule

`default_nettype wire

// File: sim/tb_coin_credit_io_controller_unit.sv
// testbench of the coin and credit i/o controller with directed tests and a predictor-checked random mix
`timescale 1ns / 1ps

module tb_coin_credit_io_controller_unit;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [3:0] JOY_DIR [16] = '{4'd5, 4'd5, 4'd5, 4'd5, 4'd7, 4'd6, 4'd7, 4'd6,
                                            4'd3, 4'd3, 4'd4, 4'd4, 4'd1, 4'd2, 4'd0, 4'd8};

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_op = '0;
    logic [3:0] s_offset = '0;
    logic [7:0] s_data = '0;
    logic [7:0] s_port_value = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [9:0] m_read_data;
    logic       m_read_valid;
    logic [1:0] m_sound_trigger;
    logic       m_nmi_running;

    // predictor state
    logic [7:0] cmd_q = '0;
    logic       mode_switch = 1'b0;
    logic [8:0] credits = '0;
    logic [7:0] par [cci_pkg::PARAM_COUNT] = '{default: '0};
    logic [7:0] rate [cci_pkg::RATE_COUNT] = '{default: '0};
    logic [7:0] coins [cci_pkg::COIN_COUNT] = '{default: '0};
    logic       nmi_en = 1'b0;

    cci_pkg::cci_result_t expected_q [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          accesses_sent = 0;
    int          ready_hold = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    coin_credit_io_controller_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_offset(s_offset),
        .s_data(s_data),
        .s_port_value(s_port_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_data(m_read_data),
        .m_read_valid(m_read_valid),
        .m_sound_trigger(m_sound_trigger),
        .m_nmi_running(m_nmi_running)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_coin_credit_io_controller_unit: done, errors");
            $finish;
        end
    end

    function automatic void count_coin(input int slot, input int bitpos, input int ri,
                                       input logic [7:0] pv);
        if (!pv[bitpos] && credits < cci_pkg::CREDIT_MAX) begin
            coins[slot] = coins[slot] + 8'd1;
            if (coins[slot] >= rate[ri]) begin
                credits = credits + 9'(rate[ri + 1]);
                coins[slot] = '0;
            end
        end
    endfunction

    function automatic bit sound_match(input logic [7:0] pat [cci_pkg::SOUND_LEN]);
        int i;
        for (i = 0; i < cci_pkg::SOUND_LEN; i++) begin
            if (par[i] != pat[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic cci_pkg::cci_result_t predict_access(input cci_pkg::cci_item_t a);
        cci_pkg::cci_result_t r;
        int i;
        int c;
        r = '0;
        case (a.op)
            cci_pkg::OP_CMD_WR: begin
                cmd_q = a.data;
                nmi_en = (a.data != cci_pkg::CMD_NMI_OFF);
            end
            cci_pkg::OP_CMD_RD: begin
                r.read_data = {2'b00, cmd_q};
                r.read_valid = 1'b1;
            end
            cci_pkg::OP_DATA_WR: begin
                par[a.offset] = a.data;
                if (cmd_q == cci_pkg::CMD_SETUP) begin
                    if (a.offset == cci_pkg::OFF_MODE) begin
                        if (a.data == cci_pkg::SETUP_SWITCH) begin
                            mode_switch = 1'b1;
                        end else begin
                            credits = '0;
                            mode_switch = 1'b0;
                        end
                    end else if (a.offset == cci_pkg::OFF_RATES) begin
                        for (i = 0; i < cci_pkg::RATE_COUNT; i++) rate[i] = par[i + 1];
                    end
                end else if (cmd_q == cci_pkg::CMD_SOUND && a.offset == cci_pkg::OFF_SOUND) begin
                    if (sound_match(cci_pkg::SOUND_PAT_A)) r.sound_trigger = cci_pkg::SND_A;
                    else if (sound_match(cci_pkg::SOUND_PAT_B)) r.sound_trigger = cci_pkg::SND_B;
                end
            end
            default: begin
                if (cmd_q == cci_pkg::CMD_READ_A || cmd_q == cci_pkg::CMD_READ_B) begin
                    if (a.offset == cci_pkg::OFF_COIN) begin
                        if (mode_switch) begin
                            r.read_data = {2'b00, a.port_value};
                        end else begin
                            if (rate[2] != 0) begin
                                count_coin(0, 4, 2, a.port_value);
                                count_coin(1, 5, 4, a.port_value);
                                count_coin(2, 6, 0, a.port_value);
                            end else begin
                                credits = cci_pkg::FREE_CREDITS;
                            end
                            if (!a.port_value[2] && credits >= 1) credits = credits - 9'd1;
                            if (!a.port_value[3] && credits >= 2) credits = credits - 9'd2;
                            c = int'(credits);
                            r.read_data = 10'((c / 10) * 16 + c % 10);
                        end
                        r.read_valid = 1'b1;
                    end else if (a.offset == cci_pkg::OFF_JOY1
                                 || a.offset == cci_pkg::OFF_JOY2) begin
                        if (mode_switch) begin
                            r.read_data = {2'b00, a.port_value};
                        end else begin
                            r.read_data = {2'b00, a.port_value[7:4],
                                           JOY_DIR[a.port_value[3:0]]};
                        end
                        r.read_valid = 1'b1;
                    end
                end else if (cmd_q == cci_pkg::CMD_PROTECT) begin
                    if (a.offset == cci_pkg::OFF_PROT) begin
                        if (par[0] == cci_pkg::PROT_KEY_A || par[0] == cci_pkg::PROT_KEY_B) begin
                            r.read_data = {2'b00, cci_pkg::PROT_OK};
                        end else begin
                            r.read_data = {2'b00, cci_pkg::PROT_FAIL};
                        end
                    end
                    r.read_valid = 1'b1;
                end
            end
        endcase
        r.nmi_running = nmi_en;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        cci_pkg::cci_result_t want;
        if (aresetn && m_valid && m_ready) begin
            ready_hold = rx_idle ? $urandom_range(0, 9) : 0;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: read_data %0h", m_read_data);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (m_read_data !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h", want.read_data, m_read_data);
                    error_count++;
                end
                if (m_read_valid !== want.read_valid) begin
                    $error("read_valid: expected %0b, got %0b", want.read_valid, m_read_valid);
                    error_count++;
                end
                if (m_sound_trigger !== want.sound_trigger) begin
                    $error("sound_trigger: expected %0d, got %0d", want.sound_trigger,
                           m_sound_trigger);
                    error_count++;
                end
                if (m_nmi_running !== want.nmi_running) begin
                    $error("nmi_running: expected %0b, got %0b", want.nmi_running, m_nmi_running);
                    error_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_access(input logic [1:0] op, input logic [3:0] off,
                               input logic [7:0] dat, input logic [7:0] pv);
        int gap;
        cci_pkg::cci_item_t a;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_offset <= off;
        s_data <= dat;
        s_port_value <= pv;
        do @(posedge aclk); while (!s_ready);
        a.op = op;
        a.offset = off;
        a.data = dat;
        a.port_value = pv;
        expected_q.push_back(predict_access(a));
        accesses_sent++;
    endtask

    task automatic cmd_write(input logic [7:0] cmd);
        send_access(cci_pkg::OP_CMD_WR, 4'($urandom_range(0, 15)), cmd,
                    8'($urandom_range(0, 255)));
    endtask

    task automatic data_write(input logic [3:0] off, input logic [7:0] dat);
        send_access(cci_pkg::OP_DATA_WR, off, dat, 8'($urandom_range(0, 255)));
    endtask

    task automatic data_read(input logic [3:0] off, input logic [7:0] pv);
        send_access(cci_pkg::OP_DATA_RD, off, 8'($urandom_range(0, 255)), pv);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_reset_reads();
        send_access(cci_pkg::OP_CMD_RD, 4'd0, 8'h00, 8'h00);
        data_read(4'd0, 8'hFF);
        cmd_write(cci_pkg::CMD_NMI_OFF);
        send_access(cci_pkg::OP_CMD_RD, 4'hF, 8'hFF, 8'hFF);
    endtask

    task automatic test_coin_credit();
        cmd_write(cci_pkg::CMD_SETUP);
        data_write(cci_pkg::OFF_MODE, 8'h00);
        data_write(4'd1, 8'd1);
        data_write(4'd2, 8'd1);
        data_write(4'd3, 8'd2);
        data_write(4'd4, 8'd3);
        data_write(4'd5, 8'd0);
        data_write(4'd6, 8'd255);
        data_write(cci_pkg::OFF_RATES, 8'h00);
        cmd_write(cci_pkg::CMD_READ_A);
        data_read(cci_pkg::OFF_COIN, 8'hEF);
        data_read(cci_pkg::OFF_COIN, 8'hEF);
        // right coin at rate zero overshoots the ceiling, aux then blocked
        data_read(cci_pkg::OFF_COIN, 8'h8F);
        data_read(cci_pkg::OFF_COIN, 8'hF3);
        data_read(cci_pkg::OFF_JOY1, 8'h5E);
        data_read(cci_pkg::OFF_JOY2, 8'hAF);
        data_read(4'd9, 8'h00);
    endtask

    task automatic test_free_play();
        cmd_write(cci_pkg::CMD_SETUP);
        data_write(4'd3, 8'd0);
        data_write(cci_pkg::OFF_RATES, 8'hFF);
        cmd_write(cci_pkg::CMD_READ_B);
        data_read(cci_pkg::OFF_COIN, 8'hFB);
    endtask

    task automatic test_switch_mode();
        cmd_write(cci_pkg::CMD_SETUP);
        data_write(cci_pkg::OFF_MODE, cci_pkg::SETUP_SWITCH);
        cmd_write(cci_pkg::CMD_READ_B);
        data_read(cci_pkg::OFF_COIN, 8'h3C);
        data_read(cci_pkg::OFF_JOY1, 8'h3C);
    endtask

    task automatic test_sound();
        int i;
        cmd_write(cci_pkg::CMD_SOUND);
        for (i = 0; i < cci_pkg::SOUND_LEN; i++) data_write(4'(i), cci_pkg::SOUND_PAT_A[i]);
    endtask

    task automatic test_protection();
        cmd_write(cci_pkg::CMD_PROTECT);
        data_read(cci_pkg::OFF_PROT, 8'h00);
        data_write(4'd0, cci_pkg::PROT_KEY_A);
        data_read(cci_pkg::OFF_PROT, 8'h00);
        data_read(4'd7, 8'hFF);
    endtask

    task automatic test_random(input int target);
        int scene;
        int n;
        int i;
        int pick;
        int bad;
        bit calm_starts;
        logic [7:0] pv;
        logic [7:0] dat;
        logic [3:0] off;
        while (accesses_sent < target) begin
            scene = $urandom_range(0, 9);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            case (scene)
                0, 1: begin
                    cmd_write(cci_pkg::CMD_SETUP);
                    if ($urandom_range(0, 3) == 0) begin
                        data_write(cci_pkg::OFF_MODE, cci_pkg::SETUP_SWITCH);
                    end else begin
                        data_write(cci_pkg::OFF_MODE, 8'($urandom_range(0, 255)));
                    end
                    for (i = 1; i <= cci_pkg::RATE_COUNT; i++) begin
                        if ($urandom_range(0, 7) == 0) dat = 8'($urandom_range(0, 255));
                        else dat = 8'($urandom_range(0, 4));
                        data_write(4'(i), dat);
                    end
                    data_write(cci_pkg::OFF_RATES, 8'($urandom_range(0, 255)));
                end
                2, 3, 4: begin
                    cmd_write($urandom_range(0, 1) ? cci_pkg::CMD_READ_A : cci_pkg::CMD_READ_B);
                    n = $urandom_range(4, 20);
                    calm_starts = ($urandom_range(0, 2) == 0);
                    for (i = 0; i < n; i++) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6) off = cci_pkg::OFF_COIN;
                        else if (pick == 6) off = cci_pkg::OFF_JOY1;
                        else if (pick == 7) off = cci_pkg::OFF_JOY2;
                        else off = 4'($urandom_range(0, 15));
                        pv = 8'($urandom_range(0, 255));
                        if (calm_starts || $urandom_range(0, 3) != 0) pv[3:2] = 2'b11;
                        data_read(off, pv);
                    end
                end
                5: begin
                    cmd_write(cci_pkg::CMD_SOUND);
                    pick = $urandom_range(0, 2);
                    bad = (pick == 2) ? $urandom_range(0, cci_pkg::SOUND_LEN - 1) : -1;
                    for (i = 0; i < cci_pkg::SOUND_LEN; i++) begin
                        dat = (pick == 1) ? cci_pkg::SOUND_PAT_B[i] : cci_pkg::SOUND_PAT_A[i];
                        if (i == bad) dat = dat ^ 8'($urandom_range(1, 255));
                        data_write(4'(i), dat);
                    end
                end
                6: begin
                    cmd_write(cci_pkg::CMD_PROTECT);
                    if ($urandom_range(0, 1)) begin
                        pick = $urandom_range(0, 2);
                        if (pick == 0) dat = cci_pkg::PROT_KEY_A;
                        else if (pick == 1) dat = cci_pkg::PROT_KEY_B;
                        else dat = 8'($urandom_range(0, 255));
                        data_write(4'd0, dat);
                    end
                    n = $urandom_range(2, 6);
                    for (i = 0; i < n; i++) begin
                        off = $urandom_range(0, 1) ? cci_pkg::OFF_PROT
                                                   : 4'($urandom_range(0, 15));
                        data_read(off, 8'($urandom_range(0, 255)));
                    end
                end
                7, 8: begin
                    n = $urandom_range(1, 5);
                    for (i = 0; i < n; i++) begin
                        send_access(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    end
                end
                default: begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0) cmd_write(cci_pkg::CMD_NMI_OFF);
                    else if (pick == 1) cmd_write(cci_pkg::CMD_READ_A);
                    else cmd_write(8'($urandom_range(0, 255)));
                    send_access(cci_pkg::OP_CMD_RD, 4'($urandom_range(0, 15)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_reads();
        test_coin_credit();
        test_free_play();
        test_switch_mode();
        // sender holds off until the pipeline is empty
        wait_drained();
        test_sound();
        test_protection();
        test_random(1300);
        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_coin_credit_io_controller_unit: done, clean");
        end else begin
            $display("tb_coin_credit_io_controller_unit: done, errors");
        end
        $finish;
    end

endmodule
